>>> src/apem_pkg.sv
// Package for the least-cost extract table: constants, action codes and state type.
`default_nettype none

package apem_pkg;

    localparam int VERTICES_DEF   = 16;
    localparam int COST_WIDTH_DEF = 16;
    localparam int VERTEX_W       = 4;
    localparam int IN_COST_W      = 16;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_SET     = 2'd1,
        ACT_REMOVE  = 2'd2,
        ACT_EXTRACT = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_DRAIN
    } state_t;

endpackage

`default_nettype wire

>>> src/apem_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module apem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/array_priority_extract_min_top.sv
// Top level of the least-cost extract table: control FSM, scan comparator, entry RAM.
//
//  channel   | signals                        | handshake
//  ----------+--------------------------------+-------------------------------------
//  command   | action, vertex, cost           | taken on start && !busy
//  result    | found, min_vertex              | done high one cycle, no stall
//
// Set and remove write the RAM in the accept cycle and
// done follows on the next edge, so a new item can be taken every cycle.
// Extract reads each entry once through the single port in S_SCAN, then S_DRAIN
// folds in the last read and writes the winner back absent.
// Clear sweeps all VERTICES entries, one write per cycle, then raises done.
// After reset the same sweep runs with busy high and no done.
// The receiver cannot stall; each item yields exactly one done pulse.
`default_nettype none

module array_priority_extract_min_top
    import apem_pkg::*;
#(
    parameter int VERTICES   = VERTICES_DEF,
    parameter int COST_WIDTH = COST_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           action,
    input  wire logic [VERTEX_W-1:0]  vertex,
    input  wire logic [IN_COST_W-1:0] cost,
    output logic                      done,
    output logic                      found,
    output logic [VERTEX_W-1:0]       min_vertex
);

    localparam int AW = $clog2(VERTICES);
    localparam int WW = COST_WIDTH + 1;                 // {present, cost}
    localparam int XW = ((AW > VERTEX_W) ? AW : VERTEX_W) + 1;

    // control and scan registers
    state_t                state_reg, state_next;
    logic [AW-1:0]         cnt_reg, cnt_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;
    logic                  have_reg, have_next;
    logic [AW-1:0]         best_idx_reg, best_idx_next;
    logic [COST_WIDTH-1:0] best_cost_reg, best_cost_next;
    logic                  done_reg, done_next;
    logic                  found_reg, found_next;
    logic [VERTEX_W-1:0]   min_vertex_reg, min_vertex_next;

    // RAM port
    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [WW-1:0]         ram_wdata;
    logic [WW-1:0]         ram_rdata;

    // decode
    action_t               act;
    logic                  accept;
    logic [XW-1:0]         vtx_x;
    logic                  vtx_ok;
    logic [AW-1:0]         vtx_addr;
    logic                  cnt_last;

    // scan compare
    logic                  rd_present;
    logic [COST_WIDTH-1:0] rd_cost;
    logic                  take;
    logic                  fin_have;
    logic [AW-1:0]         fin_idx;
    logic [COST_WIDTH-1:0] fin_cost;

    apem_ram #(
        .WIDTH (WW),
        .DEPTH (VERTICES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign act      = action_t'(action);
    assign accept   = start && (state_reg == S_IDLE);
    assign vtx_x    = XW'(vertex);
    assign vtx_ok   = (vtx_x < XW'(VERTICES));
    assign vtx_addr = vtx_x[AW-1:0];
    assign cnt_last = (cnt_reg == AW'(VERTICES - 1));

    assign rd_present = ram_rdata[COST_WIDTH];
    assign rd_cost    = ram_rdata[COST_WIDTH-1:0];
    // strict less-than keeps the lower index on a tie
    assign take       = rd_valid_reg && rd_present && (!have_reg || (rd_cost < best_cost_reg));
    assign fin_have   = have_reg || take;
    assign fin_idx    = take ? rd_idx_reg : best_idx_reg;
    assign fin_cost   = take ? rd_cost : best_cost_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            have_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_valid_next;
            have_reg     <= have_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_cost_reg  <= best_cost_next;
        found_reg      <= found_next;
        min_vertex_reg <= min_vertex_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = cnt_reg;
        have_next       = have_reg;
        best_idx_next   = best_idx_reg;
        best_cost_next  = best_cost_reg;
        done_next       = 1'b0;
        found_next      = 1'b0;
        min_vertex_next = '0;
        ram_we          = 1'b0;
        ram_addr        = cnt_reg;
        ram_wdata       = '0;

        // fold in the read issued last cycle
        if (take)
        begin
            have_next      = 1'b1;
            best_idx_next  = rd_idx_reg;
            best_cost_next = rd_cost;
        end

        case (state_reg)
            S_INIT:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    case (act)
                        ACT_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                        ACT_SET:
                        begin
                            ram_we    = vtx_ok;
                            ram_addr  = vtx_addr;
                            ram_wdata = {1'b1, COST_WIDTH'(cost)};
                            done_next = 1'b1;
                        end
                        ACT_REMOVE:
                        begin
                            ram_we    = vtx_ok;
                            ram_addr  = vtx_addr;
                            ram_wdata = '0;
                            done_next = 1'b1;
                        end
                        ACT_EXTRACT:
                        begin
                            cnt_next   = '0;
                            have_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                rd_valid_next = 1'b1;
                cnt_next      = cnt_reg + AW'(1);
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                // last read lands here; winner goes back absent
                ram_we          = fin_have;
                ram_addr        = fin_idx;
                ram_wdata       = {1'b0, fin_cost};
                done_next       = 1'b1;
                found_next      = fin_have;
                min_vertex_next = fin_have ? VERTEX_W'(fin_idx) : '0;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign found      = found_reg;
    assign min_vertex = min_vertex_reg;

    // no write may land while a scan is reading the table
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !ram_we)
        else $error("RAM write during extract scan");

    // a found item only comes out of the final scan step
    a_found_src: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> $past(state_reg == S_DRAIN))
        else $error("found raised outside extract");

    // read data is only tracked for reads the scan issued
    a_rd_src: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == S_SCAN))
        else $error("stray read valid");

    // the reset sweep gives no result
    a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |=> !done)
        else $error("result during reset sweep");

endmodule

`default_nettype wire
